// File: rtl/core/rtd_code_to_temperature_macros.svh
// Assertion macros for the RTD linearizer.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef RTD_CODE_TO_TEMPERATURE_MACROS_SVH
`define RTD_CODE_TO_TEMPERATURE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTDC_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTDC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rtdc_pkg.sv
// Shared constants and widths for the RTD code to temperature pipeline.
// No dependencies; imported by rtdc_if, rtdc_quad, rtdc_poly and the top level.
`default_nettype none

package rtdc_pkg;

  // Configuration register map and widths
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_ADDR_W-1:0] REG_RTD_NOMINAL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_RESISTOR = 2'd1;

  localparam int unsigned NOM_W = 14;
  localparam int unsigned REF_W = 17;
  localparam logic [NOM_W-1:0] NOM_RESET = 14'd100;
  localparam logic [REF_W-1:0] REF_RESET = 17'd430;

  // Ratio Rt/R0 in unsigned Q3.32
  localparam int unsigned RATIO_FRAC = 32;
  localparam int unsigned RQ_W = RATIO_FRAC + 3;
  localparam int unsigned TEMP_W = 21;

  // Quadratic branch, coefficients scaled to integers
  localparam int CVD_A = 39083;
  localparam int CVD_B = 5775;
  localparam int unsigned ROOT_SCALE_W = 28;
  localparam logic [ROOT_SCALE_W-1:0] ROOT_SCALE = 28'd231000000;
  localparam logic [63:0] CVD_A2_Q32 = 64'(longint'(CVD_A) * longint'(CVD_A)) << 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned Z_W = 33;
  // z / CVD_B as z * ceil(2^46 / CVD_B) >> 46, exact for z below 2^33
  localparam int unsigned CDIV_LAT = 2;
  localparam int unsigned CDIV_SH = 46;
  localparam int unsigned CDIV_RECIP_W = 34;
  localparam logic [CDIV_RECIP_W-1:0] CDIV_RECIP =
    34'(((64'd1 << CDIV_SH) + 64'(CVD_B - 1)) / 64'(CVD_B));
  // z = (K - 125*s) >> 6 folds the rounding and the 2^16 scale of s
  localparam logic [39:0] SQRT_TO_Z_K = 40'(longint'(125) * CVD_A * 65536 + 184800);
  localparam int unsigned QUAD_LAT = 3 + SQRT_STEPS + 1 + CDIV_LAT;

  // Polynomial branch
  localparam int unsigned U_W = RATIO_FRAC - 8;
  localparam int unsigned ACC_W = 40;
  localparam int unsigned POLY_TERMS = 5;
  localparam logic signed [ACC_W-1:0] POLY_COEF_Q16 [6] = '{
    40'(-64'sd2420200 * 64'sd65536),
    40'(64'sd2222800 * 64'sd65536),
    40'(64'sd258590 * 64'sd65536),
    40'(-64'sd48260 * 64'sd65536),
    40'(-64'sd28183 * 64'sd65536),
    40'(64'sd15243 * 64'sd65536)
  };
  localparam int unsigned WP_W = 28;
  localparam int unsigned RECIP_W = 29;
  localparam int unsigned RECIP_SH = 38;
  localparam longint POLY_ROUND = 1280000;
  localparam longint POLY_BIAS = 625 * 131072;
  localparam logic [RECIP_W-1:0] RECIP_625 = 29'(((64'd1 << RECIP_SH) + 64'd624) / 64'd625);
  localparam int unsigned POLY_LAT = 2 * POLY_TERMS + 3;
  localparam int unsigned POLY_PAD = QUAD_LAT - POLY_LAT;

endpackage

`default_nettype wire

// File: rtl/core/rtdc_if.sv
// Valid/ready channel interfaces: code input, temperature output, config write.
// Depends on rtdc_pkg.
`default_nettype none

interface rtdc_in_if #(
  parameter int unsigned CODE_BITS = 15
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] rtd_code;

  modport source (output valid, output rtd_code, input ready);
  modport sink (input valid, input rtd_code, output ready);
endinterface

interface rtdc_out_if;
  import rtdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_q8;
  logic                     out_of_range;

  modport source (output valid, output temperature_q8, output out_of_range, input ready);
  modport sink (input valid, input temperature_q8, input out_of_range, output ready);
endinterface

interface rtdc_cfg_if;
  import rtdc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rtdc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used for the ratio against the configured denominator.
`default_nettype none

module rtdc_div_pipe #(
  parameter int unsigned REM_W = 13,
  parameter int unsigned QUO_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [REM_W-1:0] rem_i,     // upper dividend bits, below divisor
  input  wire logic [QUO_W-1:0] low_i,     // dividend bits shifted in one per stage
  input  wire logic [REM_W-1:0] divisor_i,
  output logic      [QUO_W-1:0] quo_o
);

  // low word doubles as quotient: dividend bits leave at the top, quotient bits enter below
  logic [REM_W-1:0] rem_q [QUO_W-1];
  logic [QUO_W-1:0] low_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [REM_W:0]   rem_sh;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign low_in = low_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
    end

    assign rem_sh = {rem_in, low_in[QUO_W-1]};
    assign ge     = rem_sh >= {1'b0, divisor_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[s] <= {low_in[QUO_W-2:0], ge};
      end
    end

    if (s < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? REM_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[REM_W-1:0];
        end
      end
    end
  end

  assign quo_o = low_q[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/core/rtdc_quad.sv
// Quadratic Callendar-Van Dusen branch: root argument, pipelined square
// root and reciprocal divide by a constant. Depends on rtdc_pkg.
`default_nettype none

module rtdc_quad (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [rtdc_pkg::RQ_W-1:0]     rq_i,
  output logic      [rtdc_pkg::TEMP_W-1:0]   temp_o,
  output logic                               range_err_o
);
  import rtdc_pkg::*;

  localparam int unsigned FLAG_LINE = SQRT_STEPS + 1 + CDIV_LAT + 1;

  logic [RQ_W-1:0]                 x_d;
  logic [ROOT_SCALE_W+16:0]        ph_q;   // scale * x[34:18]
  logic [ROOT_SCALE_W+17:0]        pl_q;   // scale * x[17:0]
  logic [63:0]                     sub_q;
  logic [63:0]                     arg_q;
  logic [FLAG_LINE-1:0]            flag_q;
  logic [63:0]                     sx_q [SQRT_STEPS-1];
  logic [63:0]                     sr_q [SQRT_STEPS];
  logic [39:0]                     z_full;
  logic [Z_W-1:0]                  z_q;
  logic [CDIV_RECIP_W+16:0]        dh_q;   // z[32:16] * reciprocal
  logic [CDIV_RECIP_W+15:0]        dl_q;   // z[15:0] * reciprocal
  logic [CDIV_RECIP_W+32:0]        dsum;
  logic [TEMP_W-1:0]               quo_q;

  // x = rq - 1.0, wraps for ratios below one (those take the polynomial)
  assign x_d = {(RQ_W-RATIO_FRAC)'(rq_i[RQ_W-1:RATIO_FRAC] - 3'd1), rq_i[RATIO_FRAC-1:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= (ROOT_SCALE_W+17)'(ROOT_SCALE) * (ROOT_SCALE_W+17)'(x_d[RQ_W-1:18]);
      pl_q   <= (ROOT_SCALE_W+18)'(ROOT_SCALE) * (ROOT_SCALE_W+18)'(x_d[17:0]);
      sub_q  <= {1'b0, ph_q, 18'b0} + 64'(pl_q);
      arg_q  <= (sub_q > CVD_A2_Q32) ? '0 : CVD_A2_Q32 - sub_q;
      flag_q <= {flag_q[FLAG_LINE-2:0], sub_q > CVD_A2_Q32};
    end
  end

  // Digit-by-digit integer square root, two radicand bits per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] x_in;
    logic [63:0] r_in;
    logic [63:0] trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign x_in = arg_q;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = sx_q[j-1];
      assign r_in = sr_q[j-1];
    end

    assign trial = r_in + SQ_BIT;
    assign ge    = x_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_q[j] <= ge ? (r_in >> 1) + SQ_BIT : r_in >> 1;
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sx_q[j] <= ge ? x_in - trial : x_in;
        end
      end
    end
  end

  assign z_full = SQRT_TO_Z_K - 40'(sr_q[SQRT_STEPS-1][31:0]) * 40'd125;

  // z / CVD_B by reciprocal, product split in two halves of z
  assign dsum = {dh_q, 16'b0} + (CDIV_RECIP_W+33)'(dl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q   <= z_full[Z_W+5:6];
      dh_q  <= (CDIV_RECIP_W+17)'(z_q[Z_W-1:16]) * (CDIV_RECIP_W+17)'(CDIV_RECIP);
      dl_q  <= (CDIV_RECIP_W+16)'(z_q[15:0]) * (CDIV_RECIP_W+16)'(CDIV_RECIP);
      quo_q <= dsum[CDIV_SH+TEMP_W-1:CDIV_SH];
    end
  end

  assign temp_o      = quo_q;
  assign range_err_o = flag_q[FLAG_LINE-1];

endmodule

`default_nettype wire

// File: rtl/core/rtdc_poly.sv
// Fifth-order resistance polynomial for ratios below one: Horner steps in
// Q16, then floor divide by 2560000. Depends on rtdc_pkg.
`default_nettype none

module rtdc_poly (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [rtdc_pkg::U_W-1:0]          u_i,
  output logic signed [rtdc_pkg::TEMP_W-1:0]     temp_o
);
  import rtdc_pkg::*;

  logic signed [ACC_W+4:0]  ph_q  [POLY_TERMS];
  logic        [ACC_W+3:0]  pl_q  [POLY_TERMS];
  logic        [U_W-1:0]    um_q  [POLY_TERMS];
  logic signed [ACC_W-1:0]  acc_q [POLY_TERMS];
  logic        [U_W-1:0]    ua_q  [POLY_TERMS-1];
  logic signed [ACC_W:0]    v_d;
  logic        [WP_W-1:0]   wp_q;
  logic        [WP_W+RECIP_W-1:0] prod_q;
  logic signed [TEMP_W-1:0] temp_q;

  for (genvar i = 0; i < POLY_TERMS; i++) begin : g_term
    logic signed [ACC_W-1:0] acc_in;
    logic        [U_W-1:0]   u_in;
    logic signed [64:0]      sum;

    if (i == 0) begin : g_first
      assign acc_in = POLY_COEF_Q16[POLY_TERMS];
      assign u_in   = u_i;
    end else begin : g_next
      assign acc_in = acc_q[i-1];
      assign u_in   = ua_q[i-1];
    end

    // acc * u split in a signed upper and an unsigned lower half
    assign sum = (65'(ph_q[i]) <<< 20) + 65'(pl_q[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ph_q[i]  <= $signed(acc_in[ACC_W-1:20]) * $signed({1'b0, u_in});
        pl_q[i]  <= (ACC_W+4)'(acc_in[19:0]) * (ACC_W+4)'(u_in);
        um_q[i]  <= u_in;
        acc_q[i] <= sum[ACC_W+23:24] + POLY_COEF_Q16[POLY_TERMS-1-i];
      end
    end

    if (i < POLY_TERMS - 1) begin : g_u
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ua_q[i] <= um_q[i];
        end
      end
    end
  end

  // floor(x / 2560000) = floor(floor(x / 4096) / 625); bias keeps it non-negative
  assign v_d = (ACC_W+1)'(acc_q[POLY_TERMS-1]) + (ACC_W+1)'(POLY_ROUND);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wp_q   <= WP_W'(v_d[ACC_W:12] + (ACC_W-11)'(POLY_BIAS));
      prod_q <= (WP_W+RECIP_W)'(wp_q) * (WP_W+RECIP_W)'(RECIP_625);
      temp_q <= TEMP_W'(prod_q[WP_W+RECIP_W-1:RECIP_SH]) - TEMP_W'(131072);
    end
  end

  assign temp_o = temp_q;

endmodule

`default_nettype wire

// File: rtl/core/rtd_code_to_temperature.sv
// RTD ratio code to temperature, Callendar-Van Dusen linearization, top level.
// Depends on rtdc_pkg, rtdc_if, rtdc_div_pipe, rtdc_quad, rtdc_poly and the macro header.
//
//   port    dir   contents
//   in_i    sink  rtd_code[CODE_BITS]
//   out_o   src   temperature_q8[21] (1/256 degC), out_of_range
//   cfg_i   sink  addr 0: nominal ohms, addr 1: reference ohms
//
// One transaction per cycle while the skid entry is empty. Path from acceptance to the output register:
// code multiply, 35-stage ratio divider, 38-stage quadratic branch (square root
// 32 stages, reciprocal divide 2 stages); the polynomial branch runs alongside.
// Reset loads 100 and 430 ohms and clears all valid bits.
// A one-entry skid catches a result when the output stalls; while it is full
// the whole pipeline holds and in_i.ready is low.
`default_nettype none
`include "rtd_code_to_temperature_macros.svh"

module rtd_code_to_temperature #(
  parameter int unsigned CODE_BITS = 15
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rtdc_in_if.sink     in_i,
  rtdc_out_if.source  out_o,
  rtdc_cfg_if.sink    cfg_i
);
  import rtdc_pkg::*;

  localparam int unsigned NUM_W = CODE_BITS + REF_W;
  localparam int unsigned DEN_W = CODE_BITS + NOM_W;

  logic [NOM_W-1:0] nom_q;
  logic [REF_W-1:0] ref_q;
  logic             en;
  logic             v1_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den;
  logic             flag_r;
  logic [RQ_W-1:0]  rq;
  logic [RQ_W-1:0]  va_q;
  logic [RQ_W-1:0]  fa_q;
  logic [QUAD_LAT-1:0] vb_q;
  logic [QUAD_LAT-1:0] fb_q;
  logic [QUAD_LAT-1:0] pb_q;
  logic [TEMP_W-1:0]   t_quad;
  logic                quad_err;
  logic signed [TEMP_W-1:0] t_poly;
  logic signed [TEMP_W-1:0] pad_q [POLY_PAD];
  logic                vb_last;
  logic                res_flag;
  logic [TEMP_W-1:0]   res_temp;
  logic                out_valid_q;
  logic                out_take;
  logic [TEMP_W-1:0]   out_temp_q;
  logic                out_flag_q;
  logic                skid_valid_q;
  logic [TEMP_W-1:0]   skid_temp_q;
  logic                skid_flag_q;

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q <= NOM_RESET;
      ref_q <= REF_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_RTD_NOMINAL:  nom_q <= cfg_i.data[NOM_W-1:0];
        REG_REF_RESISTOR: ref_q <= cfg_i.data[REF_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid entry is free
  assign en         = !skid_valid_q;
  assign in_i.ready = en;

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= NUM_W'(in_i.rtd_code[CODE_BITS-1:0]) * NUM_W'(ref_q);
    end
  end

  assign den    = {nom_q, {CODE_BITS{1'b0}}};
  assign flag_r = (nom_q == '0) || (num_q >= {den, 3'b000});

  rtdc_div_pipe #(
    .REM_W (DEN_W),
    .QUO_W (RQ_W)
  ) u_ratio (
    .clk_i     (clk_i),
    .en_i      (en),
    .rem_i     (num_q[NUM_W-1:3]),
    .low_i     ({num_q[2:0], {RATIO_FRAC{1'b0}}}),
    .divisor_i (den),
    .quo_o     (rq)
  );

  rtdc_quad u_quad (
    .clk_i       (clk_i),
    .en_i        (en),
    .rq_i        (rq),
    .temp_o      (t_quad),
    .range_err_o (quad_err)
  );

  rtdc_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (en),
    .u_i    (rq[RATIO_FRAC-1:8]),
    .temp_o (t_poly)
  );

  // Valid bits and per-transaction flags alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      va_q <= '0;
      vb_q <= '0;
    end else if (en) begin
      v1_q <= in_i.valid;
      va_q <= {va_q[RQ_W-2:0], v1_q};
      vb_q <= {vb_q[QUAD_LAT-2:0], va_q[RQ_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_q <= {fa_q[RQ_W-2:0], flag_r};
      fb_q <= {fb_q[QUAD_LAT-2:0], fa_q[RQ_W-1]};
      pb_q <= {pb_q[QUAD_LAT-2:0], rq[RQ_W-1:RATIO_FRAC] == '0};
      pad_q[0] <= t_poly;
      for (int i = 1; i < POLY_PAD; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
    end
  end

  assign vb_last  = vb_q[QUAD_LAT-1];
  assign res_flag = fb_q[QUAD_LAT-1] || (!pb_q[QUAD_LAT-1] && quad_err);
  assign res_temp = res_flag          ? '0 :
                    pb_q[QUAD_LAT-1]  ? pad_q[POLY_PAD-1] : t_quad;

  // Output register with skid entry
  assign out_take = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= vb_last;
      end else if (vb_last) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_valid_q || out_take) begin
        out_temp_q <= res_temp;
        out_flag_q <= res_flag;
      end else begin
        skid_temp_q <= res_temp;
        skid_flag_q <= res_flag;
      end
    end else if (out_take) begin
      out_temp_q <= skid_temp_q;
      out_flag_q <= skid_flag_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.temperature_q8 = out_temp_q;
  assign out_o.out_of_range   = out_flag_q;

  `RTDC_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid full with empty output register")
  `RTDC_ASSERT_IMPL(a_flag_zero_temp, clk_i, rst_ni, out_valid_q && out_flag_q, out_temp_q == '0, "flagged result with nonzero temperature")
  `RTDC_ASSERT_NEXT(a_stall_catch, clk_i, rst_ni, out_valid_q && !out_o.ready && !skid_valid_q && vb_last, skid_valid_q, "result dropped on output stall")

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for the RTD code to temperature converter.
// Needs rtdc_pkg, the rtdc_*_if interfaces and rtd_code_to_temperature.
`timescale 1ns / 100ps

module testbench;
  import rtdc_pkg::*;

  localparam int unsigned CODE_BITS = 15;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature_q8;
    logic                     out_of_range;
  } temp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rtdc_in_if #(.CODE_BITS(CODE_BITS)) in_ch ();
  rtdc_out_if out_ch ();
  rtdc_cfg_if cfg_ch ();

  rtd_code_to_temperature #(.CODE_BITS(CODE_BITS)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always #4 clk_i = ~clk_i;

  logic [CODE_BITS-1:0] pending_codes[$];
  temp_result_t         expected_temps[$];
  logic [NOM_W-1:0]     nominal_ohms = NOM_RESET;
  logic [REF_W-1:0]     reference_ohms = REF_RESET;
  int unsigned          mismatch_cnt = 0;
  longint unsigned      cycle_cnt = 0;

  localparam longint POLY_K[6] = '{-2420200, 2222800, 258590, -48260, -28183, 15243};

  function automatic temp_result_t convert_code(logic [CODE_BITS-1:0] code,
                                                logic [NOM_W-1:0] nom,
                                                logic [REF_W-1:0] refr);
    longint unsigned num, den, rem, frac, rq, x, a2, sub, rad, root, bitv, diff, qd;
    longint          temp, u, acc, sum;
    logic            flag;
    temp_result_t    res;
    num  = longint'(code) * longint'(refr);
    den  = longint'(nom) << CODE_BITS;
    temp = 0;
    flag = 1'b0;
    if (den == 0 || num / den >= 8) begin
      flag = 1'b1;
    end else begin
      rem  = num % den;
      frac = 0;
      for (int i = 0; i < 32; i++) begin
        rem  = rem << 1;
        frac = frac << 1;
        if (rem >= den) begin
          rem  = rem - den;
          frac = frac | 1;
        end
      end
      rq = ((num / den) << 32) | frac;
      if (rq >= (64'd1 << 32)) begin
        x   = rq - (64'd1 << 32);
        a2  = (longint'(CVD_A) * CVD_A) << 32;
        sub = 64'd231000000 * x;
        if (sub > a2) begin
          flag = 1'b1;
        end else begin
          // bitwise integer square root
          rad  = a2 - sub;
          root = 0;
          bitv = 64'd1 << 62;
          while (bitv > rad) bitv = bitv >> 2;
          while (bitv != 0) begin
            if (rad >= root + bitv) begin
              rad  = rad - (root + bitv);
              root = (root >> 1) + bitv;
            end else begin
              root = root >> 1;
            end
            bitv = bitv >> 2;
          end
          diff = (longint'(CVD_A) << 16) - root;
          qd   = longint'(CVD_B) << 16;
          temp = longint'((64'd128000 * diff + qd / 2) / qd);
        end
      end else begin
        u   = longint'(rq >> 8);
        acc = POLY_K[5] * 65536;
        for (int k = 4; k >= 0; k--) acc = ((acc * u) >>> 24) + POLY_K[k] * 65536;
        sum = acc + 1280000;
        if (sum >= 0) temp = sum / 2560000;
        else temp = -(((-sum) + 2560000 - 1) / 2560000);
      end
    end
    res.temperature_q8 = temp[TEMP_W-1:0];
    res.out_of_range   = flag;
    return res;
  endfunction

  // Driver: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk_i) begin
    logic                 nxt_valid;
    logic [CODE_BITS-1:0] nxt_code;
    if (rst_ni) begin
      nxt_valid = in_ch.valid;
      nxt_code  = in_ch.rtd_code;
      if (in_ch.valid && in_ch.ready) begin
        expected_temps.push_back(convert_code(in_ch.rtd_code, nominal_ohms, reference_ohms));
        void'(pending_codes.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_codes.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_code  = pending_codes[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end
      end
      in_ch.valid    <= nxt_valid;
      in_ch.rtd_code <= nxt_code;
    end
  end

  // Monitor: ready follows a stall pattern whose density is redrawn at random
  int unsigned ready_pct = 100;
  always @(posedge clk_i) begin
    temp_result_t exp_r;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 40;
          default: ready_pct = 10;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_temps.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result transaction: temp %0d flag %0b",
                     out_ch.temperature_q8, out_ch.out_of_range);
        end else begin
          exp_r = expected_temps.pop_front();
          if (out_ch.temperature_q8 !== exp_r.temperature_q8 ||
              out_ch.out_of_range !== exp_r.out_of_range) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: temp exp %0d got %0d, flag exp %0b got %0b",
                       exp_r.temperature_q8, out_ch.temperature_q8,
                       exp_r.out_of_range, out_ch.out_of_range);
          end
        end
      end
      out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_cnt);
        $display("status: fail");
        $finish;
      end
    end
  end

  // valid is dropped after each write to keep back-to-back writes apart
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (addr == REG_RTD_NOMINAL) nominal_ohms = data[NOM_W-1:0];
    else if (addr == REG_REF_RESISTOR) reference_ohms = data[REF_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_codes.size() > 0 || in_ch.valid || expected_temps.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // random codes: mostly uniform, some clustered near unit ratio
  task automatic queue_random(int unsigned n);
    longint unsigned unit_code;
    int              c;
    unit_code = (nominal_ohms != 0 && reference_ohms != 0) ?
                (longint'(nominal_ohms) << CODE_BITS) / reference_ohms : 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        c = int'(unit_code) + $urandom_range(0, 64) - 32;
        if (c < 0) c = 0;
        if (c > 32767) c = 32767;
        pending_codes.push_back(c[CODE_BITS-1:0]);
      end else begin
        pending_codes.push_back(CODE_BITS'($urandom_range(0, 32767)));
      end
    end
  endtask

  initial begin
    logic [16:0] nom_set[8];
    logic [16:0] ref_set[8];
    in_ch.valid    = 1'b0;
    in_ch.rtd_code = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.addr    = '0;
    cfg_ch.data    = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed codes at reset values: extremes and around unit ratio
    foreach (nom_set[i]) begin end
    pending_codes = '{15'd0, 15'd1, 15'd32767, 15'd16384, 15'd7619, 15'd7620, 15'd7621,
                      15'd7622, 15'h5555, 15'h2AAA, 15'd100, 15'd3000, 15'd20000};
    wait_idle();
    // unit ratio exactly (code 1) and far above range
    write_reg(REG_RTD_NOMINAL, 17'd1);
    write_reg(REG_REF_RESISTOR, 17'd32768);
    pending_codes = '{15'd1, 15'd0, 15'd2, 15'd7, 15'd8, 15'd32767};
    wait_idle();
    // zero nominal, and writes to unused indexes
    write_reg(REG_RTD_NOMINAL, 17'd0);
    write_reg(2'd2, 17'h1FFFF);
    write_reg(2'd3, 17'h0);
    pending_codes = '{15'd0, 15'd1, 15'd32767};
    wait_idle();

    nom_set = '{17'd100, 17'd1, 17'd10000, 17'h1FFFF, 17'd1000, 17'd100, 17'd500, 17'd0};
    ref_set = '{17'd430, 17'd1, 17'd100000, 17'h1FFFF, 17'd4300, 17'd400, 17'd1, 17'd430};
    for (int p = 0; p < 9; p++) begin
      if (p < 8) begin
        write_reg(REG_RTD_NOMINAL, nom_set[p]);
        write_reg(REG_REF_RESISTOR, ref_set[p]);
      end else begin
        write_reg(REG_RTD_NOMINAL, CFG_DATA_W'($urandom_range(1, 10000)));
        write_reg(REG_REF_RESISTOR, CFG_DATA_W'($urandom_range(1, 100000)));
      end
      queue_random(80);
      // sender holds off until everything in flight is back
      wait_idle();
      queue_random(80);
      wait_idle();
    end

    if (mismatch_cnt == 0 && expected_temps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
